[hdl/scc_pkg.sv]
package scc_pkg;
  localparam int unsigned MaxVertices = 16;
  localparam int unsigned VW = 4;
  localparam int unsigned CW = 5;

  typedef enum logic [2:0] {
    StIdle,
    StFillRoot,
    StFillWalk,
    StPopFinish,
    StGatherWalk,
    StEmit,
    StClear
  } scc_state_e;
endpackage

[hdl/strongly_connected_components_core.sv]
// Strongly connected components of a directed graph of up to 16 vertices.
// Input channel (in_valid_i / in_ready_o): opcode 0 loads one edge
// source_vertex -> target_vertex into the adjacency matrix; edges with an
// endpoint at or above vertex_count are dropped. Opcode 1 starts a run: a
// sequencer walks the graph twice (Kosaraju), one stack step per cycle,
// with a single lowest-bit search unit over one matrix row or column.
// Then one beat per vertex is sent on the output channel (out_valid_o /
// out_ready_i) in index order, one per cycle while the receiver is ready,
// giving the lowest vertex of its component, with last_o on the final
// beat. A receiver stall simply holds the current beat. After the final
// beat the matrix is cleared and the block becomes ready again. The input
// is not ready during a run. vertex_count is written through
// cfg_we_i/cfg_wdata_i; the user must do so only while idle, which the
// block itself does not enforce. Reset sets it to 16, clears the matrix
// and returns to idle.
// A run with vertex_count zero emits nothing.
module strongly_connected_components_core
  import scc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [CW-1:0] cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          opcode_i,
  input  logic [VW-1:0] source_vertex_i,
  input  logic [VW-1:0] target_vertex_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [VW-1:0] vertex_o,
  output logic [VW-1:0] leader_o,
  output logic          last_o
);
  localparam int unsigned M = MaxVertices;

  scc_state_e   state_q, state_d;
  logic [CW-1:0] vcount_q;
  logic [M-1:0]  adj_q [M];
  logic [M-1:0]  visited_q, visited_d;
  logic [VW-1:0] wstack_q [M];
  logic [CW-1:0] wdepth_q, wdepth_d;
  logic [VW-1:0] fstack_q [M];
  logic [CW-1:0] fcount_q, fcount_d;
  logic [VW-1:0] lead_q [M];
  logic [CW-1:0] idx_q, idx_d;
  logic [M-1:0]  members_q, members_d;
  logic [VW-1:0] minv_q, minv_d;
  logic [CW-1:0] n;
  logic [M-1:0]  nmask, row, col, cand;
  logic [VW-1:0] top, low;
  logic          found;
  logic          push_w, pop_w, push_f;
  logic [VW-1:0] push_wv, push_fv;

  assign n = (vcount_q > CW'(M)) ? CW'(M) : vcount_q;
  always_comb begin
    for (int i = 0; i < M; i++) nmask[i] = (CW'(i) < n);
  end

  assign top = wstack_q[wdepth_q[VW-1:0] - VW'(1)];
  assign row = adj_q[top];
  always_comb begin
    for (int i = 0; i < M; i++) col[i] = adj_q[i][top];
  end
  assign cand = ((state_q == StFillWalk) ? row : col) & nmask & ~visited_q;

  // Shared lowest-set-bit search.
  always_comb begin
    found = 1'b0;
    low = '0;
    for (int i = M - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        low = VW'(i);
      end
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign vertex_o    = idx_q[VW-1:0];
  assign leader_o    = lead_q[idx_q[VW-1:0]];
  assign last_o      = (idx_q + CW'(1) == n);

  always_comb begin
    state_d   = state_q;
    visited_d = visited_q;
    wdepth_d  = wdepth_q;
    fcount_d  = fcount_q;
    idx_d     = idx_q;
    members_d = members_q;
    minv_d    = minv_q;
    push_w = 1'b0; pop_w = 1'b0; push_f = 1'b0;
    push_wv = '0; push_fv = top;
    case (state_q)
      StIdle: begin
        if (in_valid_i && opcode_i) begin
          visited_d = '0; fcount_d = '0; idx_d = '0; wdepth_d = '0;
          state_d = StFillRoot;
        end
      end
      StFillRoot: begin
        if (idx_q >= n) begin
          visited_d = '0;
          state_d = StPopFinish;
        end else if (visited_q[idx_q[VW-1:0]]) begin
          idx_d = idx_q + CW'(1);
        end else begin
          visited_d[idx_q[VW-1:0]] = 1'b1;
          push_w = 1'b1; push_wv = idx_q[VW-1:0];
          state_d = StFillWalk;
        end
      end
      StFillWalk: begin
        if (found && wdepth_q < CW'(M)) begin
          visited_d[low] = 1'b1;
          push_w = 1'b1; push_wv = low;
        end else begin
          pop_w = 1'b1;
          push_f = (fcount_q < CW'(M));
          if (wdepth_q == CW'(1)) begin
            idx_d = idx_q + CW'(1);
            state_d = StFillRoot;
          end
        end
      end
      StPopFinish: begin
        if (fcount_q == '0) begin
          idx_d = '0;
          state_d = (n == '0) ? StClear : StEmit;
        end else begin
          fcount_d = fcount_q - CW'(1);
          if (!visited_q[fstack_q[fcount_d[VW-1:0]]]) begin
            visited_d[fstack_q[fcount_d[VW-1:0]]] = 1'b1;
            push_w = 1'b1; push_wv = fstack_q[fcount_d[VW-1:0]];
            members_d = '0;
            members_d[fstack_q[fcount_d[VW-1:0]]] = 1'b1;
            minv_d = fstack_q[fcount_d[VW-1:0]];
            state_d = StGatherWalk;
          end
        end
      end
      StGatherWalk: begin
        // Children of the top are pushed one per cycle; the order of
        // membership gathering does not affect the component found.
        if (wdepth_q == '0) begin
          state_d = StPopFinish;
        end else if (found && wdepth_q < CW'(M)) begin
          visited_d[low] = 1'b1;
          members_d[low] = 1'b1;
          if (low < minv_q) minv_d = low;
          push_w = 1'b1; push_wv = low;
        end else begin
          pop_w = 1'b1;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          idx_d = idx_q + CW'(1);
          if (last_o) state_d = StClear;
        end
      end
      StClear: state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (push_w) wdepth_d = wdepth_q + CW'(1);
    else if (pop_w) wdepth_d = wdepth_q - CW'(1);
    if (push_f) fcount_d = fcount_q + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      vcount_q  <= CW'(16);
      visited_q <= '0;
      wdepth_q  <= '0;
      fcount_q  <= '0;
      idx_q     <= '0;
      members_q <= '0;
      minv_q    <= '0;
      for (int i = 0; i < M; i++) adj_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      wdepth_q  <= wdepth_d;
      fcount_q  <= fcount_d;
      idx_q     <= idx_d;
      members_q <= members_d;
      minv_q    <= minv_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (state_q == StIdle && in_valid_i && !opcode_i &&
          CW'(source_vertex_i) < n && CW'(target_vertex_i) < n)
        adj_q[source_vertex_i][target_vertex_i] <= 1'b1;
      if (state_q == StClear)
        for (int i = 0; i < M; i++) adj_q[i] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_w) wstack_q[wdepth_q[VW-1:0]] <= push_wv;
    if (push_f) fstack_q[fcount_q[VW-1:0]] <= push_fv;
    if (state_q == StGatherWalk && (wdepth_q == '0)) begin
      for (int i = 0; i < M; i++) if (members_q[i]) lead_q[i] <= minv_q;
    end
  end
endmodule

[hdl/scc_checker.sv]
module scc_checker
  import scc_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic [VW-1:0] vertex_o,
  input logic [VW-1:0] leader_o,
  input logic          last_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while emitting");
  a_leader_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> leader_o <= vertex_o) else $error("leader above vertex");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vertex_o))
    else $error("beat dropped");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o &&
    vertex_o == $past(vertex_o) + VW'(1)) else $error("vertex order");
endmodule

bind strongly_connected_components_core scc_checker u_scc_checker (.*);
